// ===== src/session_login_heartbeat_tracker_assert.svh =====
// Assertion macros for the session login and heartbeat tracker.
// Used by the top level only; no other dependencies.
`ifndef SESSION_LOGIN_HEARTBEAT_TRACKER_ASSERT_SVH
`define SESSION_LOGIN_HEARTBEAT_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define SLHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset
`define SLHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SLHT_ASSERT_NOW(label, clk, rst, ante, cons)
`define SLHT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/slht_pkg.sv =====
// Shared types and codes for the session login and heartbeat tracker.
// No dependencies.
`timescale 1ns / 1ps
package slht_pkg;

   // Operation codes of an input item
   localparam logic [2:0] OP_RESET      = 3'd0;
   localparam logic [2:0] OP_RESUME     = 3'd1;
   localparam logic [2:0] OP_LOGIN      = 3'd2;
   localparam logic [2:0] OP_LOGOUT     = 3'd3;
   localparam logic [2:0] OP_PACKET     = 3'd4;
   localparam logic [2:0] OP_BYTES      = 3'd5;
   localparam logic [2:0] OP_TICK       = 3'd6;

   // Result event codes
   localparam logic [2:0] EV_SEND_LOGIN     = 3'd0;
   localparam logic [2:0] EV_SEND_LOGOUT    = 3'd1;
   localparam logic [2:0] EV_SEND_HEARTBEAT = 3'd2;
   localparam logic [2:0] EV_ACCEPTED       = 3'd3;
   localparam logic [2:0] EV_REJECTED       = 3'd4;
   localparam logic [2:0] EV_MESSAGE        = 3'd5;
   localparam logic [2:0] EV_ENDED          = 3'd6;
   localparam logic [2:0] EV_SILENT         = 3'd7;

   // Session phases
   localparam logic [2:0] PH_CONNECTED  = 3'd0;
   localparam logic [2:0] PH_LOGIN_SENT = 3'd1;
   localparam logic [2:0] PH_LIVE       = 3'd2;
   localparam logic [2:0] PH_FAILED     = 3'd3;
   localparam logic [2:0] PH_ENDED      = 3'd4;

   // Packet type bytes
   localparam logic [7:0] PKT_ACCEPT    = 8'h41;  // 'A'
   localparam logic [7:0] PKT_REJECT    = 8'h4A;  // 'J'
   localparam logic [7:0] PKT_SEQUENCED = 8'h53;  // 'S'
   localparam logic [7:0] PKT_END       = 8'h5A;  // 'Z'

   // Control register map
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_TIMEOUT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_INTERVAL = 2'd1;
   localparam logic [63:0] SILENCE_TIMEOUT_RST    = 64'd15000000000;
   localparam logic [63:0] HEARTBEAT_INTERVAL_RST = 64'd1000000000;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] now_time;
      logic [7:0]  packet_type;
      logic        parse_ok;
      logic [63:0] sequence_value;
      logic [7:0]  reject_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [63:0] sequence_out;
      logic [7:0]  reject_out;
      logic [2:0]  session_state;
   } rsp_type;

   typedef struct packed {
      logic [63:0] silence_timeout;
      logic [63:0] heartbeat_interval;
   } cfg_type;

endpackage

// ===== src/slht_csr.sv =====
// Control registers of the session tracker: silence timeout, heartbeat interval.
// Depends on slht_pkg.
`timescale 1ns / 1ps
module slht_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_data,
   output slht_pkg::cfg_type                cfg
);
   import slht_pkg::*;

   logic [63:0] silence_ff, silence_in;
   logic [63:0] heartbeat_ff, heartbeat_in;

   // Always take a write; unknown indexes drop
   assign csr_ready = 1'b1;

   always_comb begin
      silence_in   = silence_ff;
      heartbeat_in = heartbeat_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SILENCE_TIMEOUT:    silence_in   = csr_data;
            CSR_HEARTBEAT_INTERVAL: heartbeat_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff   <= SILENCE_TIMEOUT_RST;
         heartbeat_ff <= HEARTBEAT_INTERVAL_RST;
      end else begin
         silence_ff   <= silence_in;
         heartbeat_ff <= heartbeat_in;
      end
   end

   assign cfg.silence_timeout    = silence_ff;
   assign cfg.heartbeat_interval = heartbeat_ff;

endmodule

// ===== src/slht_core.sv =====
// Session state and per-event update logic of the session tracker.
// Depends on slht_pkg.
`timescale 1ns / 1ps
module slht_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  slht_pkg::req_type item,
   input  slht_pkg::cfg_type cfg,
   output logic              res_valid,
   output slht_pkg::rsp_type res
);
   import slht_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [63:0] rx_seq_ff, rx_seq_in;
   logic [7:0]  reject_ff, reject_in;
   logic [63:0] send_time_ff, send_time_in;
   logic [63:0] recv_time_ff, recv_time_in;
   logic [63:0] recv_elapsed, send_elapsed;
   logic        silent, heartbeat_due, tick_phase;
   logic [2:0]  ev;
   logic [63:0] seq_out;

   // Elapsed times wrap at 2^64; a zero timestamp means never
   assign recv_elapsed  = item.now_time - recv_time_ff;
   assign send_elapsed  = item.now_time - send_time_ff;
   assign silent        = (recv_time_ff != 64'd0) && (recv_elapsed >= cfg.silence_timeout);
   assign heartbeat_due = (send_time_ff != 64'd0) &&
                          (send_elapsed >= cfg.heartbeat_interval);
   assign tick_phase    = (phase_ff == PH_LOGIN_SENT) || (phase_ff == PH_LIVE);

   // Decode one event into state updates and at most one result
   always_comb begin
      phase_in     = phase_ff;
      rx_seq_in    = rx_seq_ff;
      reject_in    = reject_ff;
      send_time_in = send_time_ff;
      recv_time_in = recv_time_ff;
      res_valid    = 1'b0;
      ev           = EV_SEND_LOGIN;
      seq_out      = 64'd0;
      unique case (item.operation)
         OP_RESET: begin
            phase_in     = PH_CONNECTED;
            reject_in    = 8'd0;
            send_time_in = 64'd0;
            recv_time_in = 64'd0;
         end
         OP_RESUME: begin
            rx_seq_in = item.sequence_value;
         end
         OP_LOGIN: begin
            send_time_in = item.now_time;
            phase_in     = PH_LOGIN_SENT;
            res_valid    = 1'b1;
            ev           = EV_SEND_LOGIN;
            seq_out      = rx_seq_ff;
         end
         OP_LOGOUT: begin
            send_time_in = item.now_time;
            res_valid    = 1'b1;
            ev           = EV_SEND_LOGOUT;
         end
         OP_PACKET: begin
            recv_time_in = item.now_time;
            unique case (item.packet_type)
               PKT_ACCEPT: begin
                  if (item.parse_ok) begin
                     rx_seq_in = item.sequence_value;
                     phase_in  = PH_LIVE;
                     res_valid = 1'b1;
                     ev        = EV_ACCEPTED;
                     seq_out   = item.sequence_value;
                  end
               end
               PKT_REJECT: begin
                  if (item.parse_ok) begin
                     reject_in = item.reject_value;
                  end
                  phase_in  = PH_FAILED;
                  res_valid = 1'b1;
                  ev        = EV_REJECTED;
               end
               PKT_SEQUENCED: begin
                  rx_seq_in = rx_seq_ff + 64'd1;
                  res_valid = 1'b1;
                  ev        = EV_MESSAGE;
                  seq_out   = rx_seq_ff;
               end
               PKT_END: begin
                  phase_in  = PH_ENDED;
                  res_valid = 1'b1;
                  ev        = EV_ENDED;
               end
               default: ;
            endcase
         end
         OP_BYTES: begin
            recv_time_in = item.now_time;
         end
         OP_TICK: begin
            // Silence wins over heartbeat
            if (tick_phase && silent) begin
               res_valid = 1'b1;
               ev        = EV_SILENT;
            end else if (tick_phase && heartbeat_due) begin
               send_time_in = item.now_time;
               res_valid    = 1'b1;
               ev           = EV_SEND_HEARTBEAT;
            end
         end
         default: ;
      endcase
   end

   // Result carries the reject code and phase after the event
   assign res.event_res     = ev;
   assign res.sequence_out  = seq_out;
   assign res.reject_out    = reject_in;
   assign res.session_state = phase_in;

   // Commit state only when the event retires
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CONNECTED;
         rx_seq_ff    <= 64'd0;
         reject_ff    <= 8'd0;
         send_time_ff <= 64'd0;
         recv_time_ff <= 64'd0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         rx_seq_ff    <= rx_seq_in;
         reject_ff    <= reject_in;
         send_time_ff <= send_time_in;
         recv_time_ff <= recv_time_in;
      end
   end

endmodule

// ===== src/session_login_heartbeat_tracker.sv =====
// Top level of the client session tracker: input register, core, result register.
// Depends on slht_pkg, slht_csr, slht_core and the assertion macro header.
`timescale 1ns / 1ps
`include "session_login_heartbeat_tracker_assert.svh"
// Client-side tracker for a sequenced login session. Each accepted event
// (session reset, resume, login, logout, packet, bytes arrival, tick) passes
// through an input register and one pass of update logic, then any result
// lands in a result register: rsp_valid rises in the cycle after the event
// retires from the input register, and one event is taken every cycle as
// long as rsp is drained.
// The rate is set by the single update pass, whose longest path is a 64-bit
// subtract and compare on the tick timers. Events that produce no result
// retire without touching the result register. Control registers are written
// through the csr channel, which is always ready; write them only while idle.
module session_login_heartbeat_tracker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  slht_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output slht_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [slht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                      csr_data
);
   import slht_pkg::*;

   logic    item_valid_ff, item_valid_in;
   req_type item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    core_res_valid;
   rsp_type core_res;
   cfg_type cfg;

   slht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   slht_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item_ff),
      .cfg       (cfg),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   // Retire the held item once the result register is free
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   assign item_valid_in = (req_valid && req_ready) || (item_valid_ff && !advance);
   assign rsp_valid_in  = (advance && core_res_valid) || (rsp_valid_ff && !rsp_ready);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_res_valid) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Hold off new transfers while both stages are full and stalled
   `SLHT_ASSERT_NOW(a_stall_blocks_req, clock, reset,
      item_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   // A phase outside the defined set never reaches the output
   `SLHT_ASSERT_NOW(a_phase_legal, clock, reset, rsp_valid, rsp_data.session_state <= PH_ENDED)
   // Heartbeats only come out of a login-sent or live session
   `SLHT_ASSERT_NOW(a_heartbeat_phase, clock, reset,
      rsp_valid && rsp_data.event_res == EV_SEND_HEARTBEAT,
      rsp_data.session_state == PH_LOGIN_SENT || rsp_data.session_state == PH_LIVE)
   // A retiring event with a result always shows up on the next cycle
   `SLHT_ASSERT_NEXT(a_result_lands, clock, reset, advance && core_res_valid, rsp_valid)

endmodule
